/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ttbb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttbb_pkg
// shared types and constants of the transient-triggered bass burst
// ----------------------------------------------------------------------------
package ttbb_pkg;

    // configuration register widths
    localparam int TRIG_BITS      = 15;
    localparam int STEP_BITS      = 23;
    localparam int LEN_BITS       = 16;
    localparam int ACH_BITS       = 2;
    localparam int CFG_DATA_BITS  = 23;
    localparam int CFG_INDEX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_LEVEL   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BURST_LENGTH    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_CHANNELS = 2'd3;

    // configuration reset values
    localparam logic [TRIG_BITS-1:0] TRIGGER_LEVEL_RST   = 15'd6554;
    localparam logic [STEP_BITS-1:0] PHASE_STEP_RST      = 23'd10486;
    localparam logic [LEN_BITS-1:0]  BURST_LENGTH_RST    = 16'd14400;
    localparam logic [ACH_BITS-1:0]  ACTIVE_CHANNELS_RST = 2'd2;

    // angles in Q30 used to build the sine table
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          Q_SHIFT     = 30;

    // taylor series divisors (2n)(2n+1) for n = 1..6
    localparam int TAYLOR_TERMS = 6;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // load enables of the three pipeline stages
    typedef struct packed {
        logic load_a;   // input frame taken into stage a
        logic load_b;   // stage a moves to stage b (table read)
        logic load_c;   // stage b moves to the output register
    } pipe_ctl_t;

endpackage

/* hdl/ttbb_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttbb_lane
// one channel: transient detect at the input, saturating burst mix at output
// ----------------------------------------------------------------------------
module ttbb_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  ttbb_pkg::pipe_ctl_t                 ctl,
    input  logic                                en,
    input  logic [ttbb_pkg::TRIG_BITS-1:0]      trigger_level,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic signed [SAMPLE_BITS-1:0]       sine,
    output logic                                hit,
    output logic signed [SAMPLE_BITS-1:0]       out_sample
);

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0]        mag;
    logic signed [SAMPLE_BITS-1:0] a_sample_reg;
    logic signed [SAMPLE_BITS-1:0] b_sample_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic signed [SAMPLE_BITS:0]   sum;
    logic signed [SAMPLE_BITS-1:0] sat;

    // magnitude compare; the most negative value reads as 2^(n-1)
    always_comb
    begin
        mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
        hit = en && (32'(mag) > 32'(trigger_level));
    end

    // sample travels alongside the control pipeline
    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            a_sample_reg <= sample;
        end
        if (ctl.load_b)
        begin
            b_sample_reg <= a_sample_reg;
        end
        if (ctl.load_c)
        begin
            out_reg <= en ? sat : '0;
        end
    end

    // add burst value and clamp to full scale
    always_comb
    begin
        sum = {b_sample_reg[SAMPLE_BITS-1], b_sample_reg} + {sine[SAMPLE_BITS-1], sine};
        if (sum[SAMPLE_BITS] != sum[SAMPLE_BITS-1])
        begin
            sat = sum[SAMPLE_BITS] ? SMIN : SMAX;
        end
        else
        begin
            sat = sum[SAMPLE_BITS-1:0];
        end
    end

    assign out_sample = out_reg;

endmodule

/* hdl/ttbb_burst.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttbb_burst
// burst sequencer: frame countdown, phase accumulator and sine table read
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttbb_burst #(
    parameter int SAMPLE_BITS    = 16,
    parameter int PHASE_BITS     = 24,
    parameter int SINE_ROM_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ttbb_pkg::pipe_ctl_t              ctl,
    input  logic                             any_hit,
    input  logic [ttbb_pkg::STEP_BITS-1:0]   phase_step,
    input  logic [ttbb_pkg::LEN_BITS-1:0]    burst_length,
    output logic signed [SAMPLE_BITS-1:0]    sine,
    output logic                             burst_active
);

    localparam int ADDR_BITS = $clog2(SINE_ROM_DEPTH);
    localparam int PROD_BITS = PHASE_BITS + ADDR_BITS + 1;
    localparam logic [63:0] SMAX = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef logic signed [SAMPLE_BITS-1:0] rom_t [SINE_ROM_DEPTH];

    // table entry k = round(SMAX * sin(2*pi*k/depth)), taylor series in Q30
    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] th;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum_q;
        logic [63:0] v;
        logic        neg;
        for (int k = 0; k < SINE_ROM_DEPTH; k++)
        begin
            th  = (ttbb_pkg::TWO_PI_Q30 * 64'(k)) / SINE_ROM_DEPTH;
            neg = 1'b0;
            if (th > ttbb_pkg::PI_Q30)
            begin
                th  = ttbb_pkg::TWO_PI_Q30 - th;
                neg = 1'b1;
            end
            if (th > ttbb_pkg::HALF_PI_Q30)
            begin
                th = ttbb_pkg::PI_Q30 - th;
            end
            x     = th;
            x2    = (x * x) >> ttbb_pkg::Q_SHIFT;
            term  = x;
            sum_q = x;
            for (int n = 1; n <= ttbb_pkg::TAYLOR_TERMS; n++)
            begin
                term = ((term * x2) >> ttbb_pkg::Q_SHIFT) / ttbb_pkg::TAYLOR_DIV[n-1];
                if ((n & 1) != 0)
                begin
                    sum_q = (sum_q >= term) ? sum_q - term : 64'd0;
                end
                else
                begin
                    sum_q = sum_q + term;
                end
            end
            v = (sum_q * SMAX + (64'd1 << (ttbb_pkg::Q_SHIFT - 1))) >> ttbb_pkg::Q_SHIFT;
            if (v > SMAX)
            begin
                v = SMAX;
            end
            rom[k] = neg ? -SAMPLE_BITS'(v) : SAMPLE_BITS'(v);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [ttbb_pkg::LEN_BITS-1:0] frames_left_reg, frames_left_next;
    logic [PHASE_BITS-1:0]         sine_phase_reg, sine_phase_next;
    logic [31:0]                   step_wide;
    logic [PHASE_BITS-1:0]         step_p;
    logic                          busy;
    logic                          trig_hit;
    logic [ttbb_pkg::LEN_BITS-1:0] frames_eff;
    logic [PHASE_BITS-1:0]         phase_eff;
    logic                          active;
    logic [PROD_BITS-1:0]          prod;
    logic [ADDR_BITS-1:0]          addr;
    logic [ADDR_BITS-1:0]          a_addr_reg;
    logic                          a_active_reg;
    logic signed [SAMPLE_BITS-1:0] sine_b_reg;
    logic                          b_active_reg;
    logic                          c_active_reg;

    // phase step masked to the accumulator width
    assign step_wide = 32'(phase_step);
    assign step_p    = step_wide[PHASE_BITS-1:0];

    // burst decision for the frame at the input
    always_comb
    begin
        busy       = (frames_left_reg != '0);
        trig_hit   = !busy && any_hit;
        frames_eff = trig_hit ? burst_length : frames_left_reg;
        phase_eff  = trig_hit ? '0 : sine_phase_reg;
        active     = (frames_eff != '0);
        prod       = PROD_BITS'(phase_eff) * PROD_BITS'(SINE_ROM_DEPTH);
        addr       = prod[PHASE_BITS +: ADDR_BITS];

        frames_left_next = frames_left_reg;
        sine_phase_next  = sine_phase_reg;
        if (ctl.load_a)
        begin
            frames_left_next = active ? frames_eff - 1'b1 : frames_eff;
            sine_phase_next  = active ? phase_eff + step_p : phase_eff;
        end
    end

    // burst state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_left_reg <= '0;
            sine_phase_reg  <= '0;
        end
        else
        begin
            frames_left_reg <= frames_left_next;
            sine_phase_reg  <= sine_phase_next;
        end
    end

    // table address, registered table read, active flag to the output
    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            a_addr_reg   <= addr;
            a_active_reg <= active;
        end
        if (ctl.load_b)
        begin
            sine_b_reg   <= a_active_reg ? SINE_ROM[a_addr_reg] : '0;
            b_active_reg <= a_active_reg;
        end
        if (ctl.load_c)
        begin
            c_active_reg <= b_active_reg;
        end
    end

    assign sine         = sine_b_reg;
    assign burst_active = c_active_reg;

    // checks
    `ASSERT_NEXT(a_count_down, ctl.load_a && (frames_left_reg != '0), frames_left_reg == $past(frames_left_reg) - 1'b1, "burst countdown did not step by one")
    `ASSERT_NEXT(a_phase_start, ctl.load_a && trig_hit && (burst_length != '0), sine_phase_reg == step_p, "burst did not start at phase zero")
    `ASSERT_NEXT(a_busy_active, ctl.load_a && busy, a_active_reg, "frame inside a burst not marked active")

endmodule

/* hdl/transient_triggered_bass_burst.sv */
`timescale 1ns / 1ps
// Each frame passes stage a, stage b and the output register. Throughput: one
// frame per cycle unless m_tready stalls the output; the sine table read and
// the saturating mix each take one registered stage; every stage moves on its
// own ready. Reset: rst_n clears the pipeline, ends any burst (phase zero) and
// restores the register defaults; the sine table is constant and needs no fill.
// ----------------------------------------------------------------------------
// transient_triggered_bass_burst
// adds a sine burst to every active channel when a transient exceeds the trigger level
// ----------------------------------------------------------------------------
module transient_triggered_bass_burst #(
    parameter int CHANNELS       = 2,
    parameter int SAMPLE_BITS    = 16,
    parameter int PHASE_BITS     = 24,
    parameter int SINE_ROM_DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // input frames
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample_ch0, sample_ch1, ...
    // output frames
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,  // out_ch0, out_ch1, ...
    output logic                                     m_tuser,  // burst_active
    // register writes
    input  logic                                     cfg_we,
    input  logic [ttbb_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [ttbb_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    logic [ttbb_pkg::TRIG_BITS-1:0] trigger_level_reg, trigger_level_next;
    logic [ttbb_pkg::STEP_BITS-1:0] phase_step_reg, phase_step_next;
    logic [ttbb_pkg::LEN_BITS-1:0]  burst_length_reg, burst_length_next;
    logic [ttbb_pkg::ACH_BITS-1:0]  active_channels_reg, active_channels_next;

    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic out_valid_reg, out_valid_next;
    logic a_ready, b_ready, c_ready;

    ttbb_pkg::pipe_ctl_t            ctl;
    logic [CHANNELS-1:0]            lane_hit;
    logic [CHANNELS-1:0]            lane_en;
    logic                           any_hit;
    logic signed [SAMPLE_BITS-1:0]  sine;
    logic                           burst_active;
    logic signed [SAMPLE_BITS-1:0]  lane_out [CHANNELS];

    // register writes
    always_comb
    begin
        trigger_level_next   = trigger_level_reg;
        phase_step_next      = phase_step_reg;
        burst_length_next    = burst_length_reg;
        active_channels_next = active_channels_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ttbb_pkg::REG_TRIGGER_LEVEL:
                    trigger_level_next = cfg_data[ttbb_pkg::TRIG_BITS-1:0];
                ttbb_pkg::REG_PHASE_STEP:
                    phase_step_next = cfg_data[ttbb_pkg::STEP_BITS-1:0];
                ttbb_pkg::REG_BURST_LENGTH:
                    burst_length_next = cfg_data[ttbb_pkg::LEN_BITS-1:0];
                ttbb_pkg::REG_ACTIVE_CHANNELS:
                    active_channels_next = cfg_data[ttbb_pkg::ACH_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_level_reg   <= ttbb_pkg::TRIGGER_LEVEL_RST;
            phase_step_reg      <= ttbb_pkg::PHASE_STEP_RST;
            burst_length_reg    <= ttbb_pkg::BURST_LENGTH_RST;
            active_channels_reg <= ttbb_pkg::ACTIVE_CHANNELS_RST;
        end
        else
        begin
            trigger_level_reg   <= trigger_level_next;
            phase_step_reg      <= phase_step_next;
            burst_length_reg    <= burst_length_next;
            active_channels_reg <= active_channels_next;
        end
    end

    // per-stage handshake: a stage loads when it is empty or the next one takes it
    always_comb
    begin
        c_ready    = !out_valid_reg || m_tready;
        b_ready    = !b_valid_reg || c_ready;
        a_ready    = !a_valid_reg || b_ready;
        ctl.load_a = s_tvalid && a_ready;
        ctl.load_b = a_valid_reg && b_ready;
        ctl.load_c = b_valid_reg && c_ready;

        a_valid_next   = a_ready ? s_tvalid : a_valid_reg;
        b_valid_next   = b_ready ? a_valid_reg : b_valid_reg;
        out_valid_next = c_ready ? b_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = a_ready;
    assign m_tvalid = out_valid_reg;

    // channel lanes; channel zero is always in use
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        assign lane_en[c] = (c == 0) || (32'(c) < 32'(active_channels_reg));

        ttbb_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk           (clk),
            .ctl           (ctl),
            .en            (lane_en[c]),
            .trigger_level (trigger_level_reg),
            .sample        (s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
            .sine          (sine),
            .hit           (lane_hit[c]),
            .out_sample    (lane_out[c])
        );
    end

    // merge: any lane over the level triggers
    assign any_hit = |lane_hit;

    ttbb_burst #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
    ) u_burst (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .any_hit      (any_hit),
        .phase_step   (phase_step_reg),
        .burst_length (burst_length_reg),
        .sine         (sine),
        .burst_active (burst_active)
    );

    // merge: pack lane results into the output transfer
    always_comb
    begin
        m_tdata = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] = lane_out[c];
        end
    end

    assign m_tuser = burst_active;

endmodule
